// ----- sv/assert_macros.svh -----
// assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/q2e_pkg.sv -----
// shared constants and cordic angle table for the quaternion to euler core
package q2e_pkg;
  localparam int ATAN_LEN = 24;
  localparam int DW = 36;

  function automatic logic [31:0] atan_step(input int i);
    logic [31:0] t;
    begin
      case (i)
        0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
        3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
        6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
        9: t = 32'h00145F2E;  10: t = 32'h000A2F98; 11: t = 32'h000517CC;
        12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2F9;
        15: t = 32'h0000517C; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
        18: t = 32'h00000A2F; 19: t = 32'h00000517; 20: t = 32'h0000028B;
        21: t = 32'h00000145; 22: t = 32'h000000A2; 23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction
endpackage

// ----- sv/quaternion_to_euler_core.sv -----
// quaternion to zyx euler angle core, top level
//  channel  | ports                                  | handshake
//  input    | in_quat_x/y/z/w                        | start & !busy
//  result   | out_roll/pitch/yaw_angle, out_norm_ok  | out_valid strobe, no stall
//  config   | cfg_norm_tolerance                     | cfg_valid & cfg_ready
// one item per cycle; busy is always low, the pipeline never stalls
// latency is set by the pitch path
// (square root stages then a cordic); roll and yaw are delayed to match
// rst_n clears the valid bits and sets the tolerance register to 164, nothing else
module quaternion_to_euler_core #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_norm_ok,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic        [13:0] cfg_norm_tolerance
);
  localparam int SQ_LAT = 30;                         // square root pipeline, its input reg included
  localparam int CD_LAT = ANGLE_ITERATIONS + 2;
  localparam int LAT = 2 + 1 + SQ_LAT + CD_LAT;       // front, square reg, sqrt, cordic
  localparam int ITER = (ANGLE_ITERATIONS < q2e_pkg::ATAN_LEN) ?
                        ANGLE_ITERATIONS : q2e_pkg::ATAN_LEN;

  logic [13:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= 14'd164;
    else if (cfg_valid) tol_r <= cfg_norm_tolerance;
  end
  assign cfg_ready = 1'b1;
  assign busy = 1'b0;

  logic signed [35:0] sr, cr, sy, cy, sp;
  logic norm_ok;
  q2e_front u_front (
    .clk, .qx(in_quat_x), .qy(in_quat_y), .qz(in_quat_z), .qw(in_quat_w),
    .tol(tol_r), .sr, .cr, .sy, .cy, .sp, .norm_ok
  );

  // pitch: square term, then root, then cordic
  // the radicand only matters below one, where the term fits in 29 bits
  logic signed [35:0] sp_r;
  logic [56:0] rad_r;
  logic [1:0] clamp_r;
  logic signed [28:0] sp_lo;
  logic signed [57:0] sp2;
  assign sp_lo = sp[28:0];
  assign sp2 = sp_lo * sp_lo;
  always_ff @(posedge clk) begin
    sp_r <= sp;
    rad_r <= 57'(58'sh100000000000000 - sp2);
    clamp_r <= {sp <= -36'sd268435456, sp >= 36'sd268435456};
  end

  logic [28:0] root;
  q2e_isqrt u_sqrt (.clk, .rad_in(rad_r), .root);

  logic signed [35:0] sp_d [SQ_LAT];
  logic [1:0] cl_d [SQ_LAT + CD_LAT];
  always_ff @(posedge clk) begin
    sp_d[0] <= sp_r;
    cl_d[0] <= clamp_r;
  end
  for (genvar i = 1; i < SQ_LAT; i++) begin : g_spd
    always_ff @(posedge clk) sp_d[i] <= sp_d[i-1];
  end
  for (genvar i = 1; i < SQ_LAT + CD_LAT; i++) begin : g_cld
    always_ff @(posedge clk) cl_d[i] <= cl_d[i-1];
  end

  // root arrives after 30 regs from rad_r; align sp with it
  logic [15:0] pitch_raw;
  q2e_cordic #(.ITER(ITER), .LAT_PAD(0)) u_pitch (
    .clk, .y_in(sp_d[SQ_LAT-1]), .x_in(36'(root)), .angle(pitch_raw)
  );

  logic [15:0] roll_a, yaw_a;
  q2e_cordic #(.ITER(ITER), .LAT_PAD(SQ_LAT + 1)) u_roll (
    .clk, .y_in(sr), .x_in(cr), .angle(roll_a)
  );
  q2e_cordic #(.ITER(ITER), .LAT_PAD(SQ_LAT + 1)) u_yaw (
    .clk, .y_in(sy), .x_in(cy), .angle(yaw_a)
  );

  logic norm_d [LAT-2];
  always_ff @(posedge clk) norm_d[0] <= norm_ok;
  for (genvar i = 1; i < LAT - 2; i++) begin : g_nd
    always_ff @(posedge clk) norm_d[i] <= norm_d[i-1];
  end

  logic vld_r [LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else vld_r[0] <= start;
  end
  for (genvar i = 1; i < LAT; i++) begin : g_vld
    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[i] <= 1'b0;
      else vld_r[i] <= vld_r[i-1];
    end
  end

  logic [1:0] cl_out;
  assign cl_out = cl_d[SQ_LAT + CD_LAT - 1];
  assign out_valid = vld_r[LAT-1];
  assign out_roll_angle = roll_a;
  assign out_yaw_angle = yaw_a;
  assign out_pitch_angle = cl_out[0] ? 16'sd16384 :
                           cl_out[1] ? -16'sd16384 : pitch_raw;
  assign out_norm_ok = norm_d[LAT-3];
endmodule

// ----- sv/q2e_cordic.sv -----
// pipelined vectoring cordic, one stage per iteration, registered output angle
module q2e_cordic #(
  parameter int ITER = 16,
  parameter int LAT_PAD = 0
) (
  input  logic                            clk,
  input  logic signed [q2e_pkg::DW-1:0]   y_in,
  input  logic signed [q2e_pkg::DW-1:0]   x_in,
  output logic        [15:0]              angle
);
  localparam int W = q2e_pkg::DW + 2;

  logic signed [W-1:0] x_r [ITER+1];
  logic signed [W-1:0] y_r [ITER+1];
  logic        [31:0]  z_r [ITER+1];
  logic                zero_r [ITER+1];
  logic        [15:0]  pad_r [LAT_PAD+1];

  // prerotation into the right half plane
  always_ff @(posedge clk) begin
    zero_r[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      x_r[0] <= -W'(x_in);
      y_r[0] <= -W'(y_in);
      z_r[0] <= 32'h80000000;
    end else begin
      x_r[0] <= W'(x_in);
      y_r[0] <= W'(y_in);
      z_r[0] <= 32'h0;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    always_ff @(posedge clk) begin
      zero_r[i+1] <= zero_r[i];
      if (y_r[i] >= 0) begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + q2e_pkg::atan_step(i);
      end else begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - q2e_pkg::atan_step(i);
      end
    end
  end

  logic [31:0] zr;
  assign zr = z_r[ITER] + 32'h8000;

  always_ff @(posedge clk) begin
    pad_r[0] <= zero_r[ITER] ? 16'h0 : zr[31:16];
  end
  for (genvar p = 0; p < LAT_PAD; p++) begin : g_pad
    always_ff @(posedge clk) pad_r[p+1] <= pad_r[p];
  end
  assign angle = pad_r[LAT_PAD];
endmodule

// ----- sv/q2e_isqrt.sv -----
// pipelined restoring square root of 2^56 - s^2, one result bit per stage
module q2e_isqrt (
  input  logic               clk,
  input  logic [56:0]        rad_in,
  output logic [28:0]        root
);
  // 57-bit radicand, 29 result bits, each stage takes two radicand bits
  localparam int N = 29;
  logic [57:0] rem_r  [N+1];
  logic [28:0] q_r    [N+1];
  logic [57:0] src_r  [N+1];

  always_ff @(posedge clk) begin
    rem_r[0] <= '0;
    q_r[0]   <= '0;
    src_r[0] <= {1'b0, rad_in};
  end

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [31:0] trial_rem;
    logic [31:0] trial;
    always_comb begin
      trial_rem = {rem_r[i][29:0], src_r[i][57:56]};
      trial     = {1'b0, q_r[i], 2'b01};
    end
    always_ff @(posedge clk) begin
      src_r[i+1] <= {src_r[i][55:0], 2'b00};
      if (trial_rem >= trial) begin
        rem_r[i+1] <= 58'(trial_rem - trial);
        q_r[i+1]   <= {q_r[i][27:0], 1'b1};
      end else begin
        rem_r[i+1] <= 58'(trial_rem);
        q_r[i+1]   <= {q_r[i][27:0], 1'b0};
      end
    end
  end
  assign root = q_r[N];
endmodule

// ----- sv/q2e_front.sv -----
// products of quaternion components, sums for the angle terms and norm check
module q2e_front (
  input  logic               clk,
  input  logic signed [15:0] qx,
  input  logic signed [15:0] qy,
  input  logic signed [15:0] qz,
  input  logic signed [15:0] qw,
  input  logic        [13:0] tol,
  output logic signed [35:0] sr,
  output logic signed [35:0] cr,
  output logic signed [35:0] sy,
  output logic signed [35:0] cy,
  output logic signed [35:0] sp,
  output logic               norm_ok
);
  logic signed [31:0] xx_r, yy_r, zz_r, ww_r, wx_r, yz_r, wy_r, zx_r, wz_r, xy_r;
  logic [29:0] lo2_r, hi2_r;
  logic [14:0] lo_r, hi_r;

  always_ff @(posedge clk) begin
    xx_r <= qx * qx; yy_r <= qy * qy; zz_r <= qz * qz; ww_r <= qw * qw;
    wx_r <= qw * qx; yz_r <= qy * qz; wy_r <= qw * qy; zx_r <= qz * qx;
    wz_r <= qw * qz; xy_r <= qx * qy;
    lo_r <= 15'(15'd16384 - 15'(tol));
    hi_r <= 15'(15'd16384 + 15'(tol));
  end

  logic [33:0] mag2;
  assign mag2 = 34'(xx_r) + 34'(yy_r) + 34'(zz_r) + 34'(ww_r);

  logic [33:0] mag2_r;
  always_ff @(posedge clk) begin
    sr <= 36'(2 * (36'(wx_r) + 36'(yz_r)));
    cr <= 36'(36'sd268435456 - 2 * (36'(xx_r) + 36'(yy_r)));
    sy <= 36'(2 * (36'(wz_r) + 36'(xy_r)));
    cy <= 36'(36'sd268435456 - 2 * (36'(yy_r) + 36'(zz_r)));
    sp <= 36'(2 * (36'(wy_r) - 36'(zx_r)));
    mag2_r <= mag2;
    lo2_r <= lo_r * lo_r;
    hi2_r <= hi_r * hi_r;
  end
  assign norm_ok = (mag2_r >= 34'(lo2_r)) && (mag2_r <= 34'(hi2_r));
endmodule

// ----- sv/q2e_checker.sv -----
// port level checks for the quaternion to euler core
`include "assert_macros.svh"
module q2e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [15:0] out_pitch_angle,
  input logic               cfg_ready
);
  logic pitch_in_rng;
  assign pitch_in_rng = (out_pitch_angle <= 16'sd16384) && (out_pitch_angle >= -16'sd16384);

  `CHK_IMPL(a_no_busy, clk, rst_n, 1'b1, !busy, "core reported busy")
  `CHK_IMPL(a_cfg_rdy, clk, rst_n, 1'b1, cfg_ready, "config not ready")
  `CHK_IMPL(a_pitch_rng, clk, rst_n, out_valid, pitch_in_rng, "pitch out of range")
  `CHK_NEXT(a_rst_idle, clk, 1'b1, !rst_n, !out_valid, "result after reset")
endmodule

bind quaternion_to_euler_core q2e_checker u_q2e_checker (
  .clk, .rst_n, .busy, .out_valid, .out_pitch_angle, .cfg_ready
);
